@@ rtl/slkp_pkg.sv @@
package slkp_pkg;

  localparam int unsigned KEY_W   = 3;
  localparam int unsigned EVENT_W = 6;
  localparam int unsigned TICKS_W = 16;

  localparam logic [KEY_W-1:0]   KEY_MASK_ALL     = 3'h7;
  localparam logic [KEY_W-1:0]   KEY_RED          = 3'b100;
  localparam logic [KEY_W-1:0]   KEY_YELLOW       = 3'b010;
  localparam logic [KEY_W-1:0]   KEY_GREEN        = 3'b001;
  localparam logic [TICKS_W-1:0] LONG_TICKS_RESET = 16'h00ff;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] pin_levels;
  } in_word_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_bits;
    logic [KEY_W-1:0]   held_mask;
  } out_word_t;

endpackage

@@ rtl/slkp_tracker.sv @@
module slkp_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  slkp_pkg::in_word_t             in_word,
  input  logic [slkp_pkg::TICKS_W-1:0]   long_press_ticks,
  output slkp_pkg::out_word_t            result
);

  logic [slkp_pkg::KEY_W-1:0]   last_pressed, last_pressed_next;
  logic [slkp_pkg::KEY_W-1:0]   held_key, held_key_next;
  logic [slkp_pkg::EVENT_W-1:0] pending_events, pending_events_next;
  logic                         timeout_armed, timeout_armed_next;
  logic [slkp_pkg::TICKS_W-1:0] ticks_left, ticks_left_next;

  logic [slkp_pkg::KEY_W-1:0]   now_down;
  logic [slkp_pkg::KEY_W-1:0]   changed;
  logic [slkp_pkg::KEY_W-1:0]   pressed;
  logic [slkp_pkg::KEY_W-1:0]   released;
  logic [slkp_pkg::EVENT_W-1:0] events_out;

  assign now_down = ~in_word.pin_levels & slkp_pkg::KEY_MASK_ALL;
  assign changed  = last_pressed ^ now_down;
  assign pressed  = changed & now_down;
  assign released = changed & last_pressed & held_key;

  always_comb begin
    last_pressed_next   = last_pressed;
    held_key_next       = held_key;
    pending_events_next = pending_events;
    timeout_armed_next  = timeout_armed;
    ticks_left_next     = ticks_left;
    events_out          = '0;
    case (slkp_pkg::cmd_t'(in_word.cmd))
      slkp_pkg::CMD_SAMPLE: begin
        last_pressed_next = now_down;
        // latch the highest-priority new press, red first
        if (held_key == '0) begin
          if (pressed[2]) begin
            held_key_next      = slkp_pkg::KEY_RED;
            timeout_armed_next = 1'b1;
            ticks_left_next    = long_press_ticks;
          end else if (pressed[1]) begin
            held_key_next      = slkp_pkg::KEY_YELLOW;
            timeout_armed_next = 1'b1;
            ticks_left_next    = long_press_ticks;
          end else if (pressed[0]) begin
            held_key_next      = slkp_pkg::KEY_GREEN;
            timeout_armed_next = 1'b1;
            ticks_left_next    = long_press_ticks;
          end
        end
        if (released != '0) begin
          held_key_next       = '0;
          timeout_armed_next  = 1'b0;
          ticks_left_next     = '0;
          pending_events_next = pending_events | {3'b000, released};
        end
      end
      slkp_pkg::CMD_TICK: begin
        if (timeout_armed) begin
          if (ticks_left <= 16'd1) begin
            pending_events_next = pending_events | {held_key & now_down, 3'b000};
            held_key_next       = '0;
            timeout_armed_next  = 1'b0;
            ticks_left_next     = '0;
          end else begin
            ticks_left_next = ticks_left - 16'd1;
          end
        end
      end
      slkp_pkg::CMD_READ: begin
        events_out          = pending_events;
        pending_events_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign result.event_bits = events_out;
  assign result.held_mask  = held_key_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed   <= '0;
      held_key       <= '0;
      pending_events <= '0;
      timeout_armed  <= 1'b0;
      ticks_left     <= '0;
    end else if (accept) begin
      last_pressed   <= last_pressed_next;
      held_key       <= held_key_next;
      pending_events <= pending_events_next;
      timeout_armed  <= timeout_armed_next;
      ticks_left     <= ticks_left_next;
    end
  end

`ifndef SYNTH
  a_held_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(held_key))
    else $error("held key not one-hot");

  a_armed_with_held: assert property (@(posedge clk) disable iff (rst)
    (held_key != '0) == timeout_armed)
    else $error("countdown armed state disagrees with held key");

  a_idle_count_zero: assert property (@(posedge clk) disable iff (rst)
    !timeout_armed |-> (ticks_left == '0))
    else $error("ticks left while disarmed");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.cmd == slkp_pkg::CMD_READ) |=> (pending_events == '0))
    else $error("pending events not cleared by read");
`endif

endmodule

@@ rtl/short_long_key_press_detector_core.sv @@
// Channel  Direction  Payload               Handshake
// in       input      in_data (cmd, pins)   in_valid / in_ready
// out      output     out_data (events,     out_valid / out_ready
//                     held_mask)
// cfg      input      cfg_data (16 bits)    cfg_we, no wait
//
// One word is taken per cycle; its result shows in out_data the cycle after.
// The key state updates on the accepting edge and the result word sits in
// a single output register, so in_ready is high whenever that register is
// empty or being drained. A stalled out channel holds in_ready low.
// Synchronous reset clears key state, the output valid and sets the long
// press register to 255.
module short_long_key_press_detector_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  slkp_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output slkp_pkg::out_word_t           out_data,
  input  logic                          cfg_we,
  input  logic [slkp_pkg::TICKS_W-1:0]  cfg_data
);

  logic [slkp_pkg::TICKS_W-1:0] long_press_ticks;
  slkp_pkg::out_word_t          result;
  logic                         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= slkp_pkg::LONG_TICKS_RESET;
    end else if (cfg_we) begin
      long_press_ticks <= cfg_data;
    end
  end

  slkp_tracker u_tracker (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .in_word          (in_data),
    .long_press_ticks (long_press_ticks),
    .result           (result)
  );

  // hold the result word until taken; refill on the same edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule
